// ===== src/ksel_pkg.sv =====
// Shared constants, types and state encoding for the k-th smallest heap select block.
package ksel_pkg;

  // Field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned KCNT_W   = 7;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 2;

  // Default heap capacity
  localparam int unsigned MAX_K_DEF = 64;

  // Register byte addresses
  localparam logic [APB_AW-1:0] ADDR_K_COUNT = 2'd0;

  // Sign flip so unsigned compare matches signed order
  localparam logic [DATA_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // Heap engine sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_PUT,
    ST_FIN
  } ksel_state_e;

endpackage

// ===== src/ksel_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
interface ksel_item_if import ksel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ksel_result_if import ksel_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] kth_smallest;
  logic                     short_set;

  modport source (output valid, output kth_smallest, output short_set, input ready);
  modport sink   (input valid, input kth_smallest, input short_set, output ready);
endinterface

// ===== src/ksel_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ksel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/ksel_heap.sv =====
// Max-heap engine: insert with sift-up, root replace with sift-down, result register.
module ksel_heap import ksel_pkg::*; #(
  parameter int unsigned MAX_K = MAX_K_DEF,
  localparam int unsigned KW   = $clog2(MAX_K + 1),
  localparam int unsigned AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [KW-1:0]   eff_k_i,
  ksel_item_if.sink       item_i,
  ksel_result_if.source   result_o
);

  localparam int unsigned CW = AW + 2;

  ksel_state_e state_q, state_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] root_q, root_d;
  logic [DATA_W-1:0] left_q, left_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [KW-1:0]     fill_q, fill_d;
  logic              last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_kth_q, out_kth_d;
  logic              out_short_q, out_short_d;

  // Memory port signals
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  // Heap index arithmetic
  logic [AW-1:0]     parent;
  logic [CW-1:0]     left_c;
  logic [CW-1:0]     right_c;
  logic [CW-1:0]     fill_c;
  logic [DATA_W-1:0] in_val;
  logic              have_right;
  logic              short_now;

  assign parent     = AW'((pos_q - AW'(1)) >> 1);
  assign left_c     = CW'({pos_q, 1'b1});
  assign right_c    = left_c + CW'(1);
  assign fill_c     = CW'(fill_q);
  assign have_right = right_c < fill_c;
  assign in_val     = DATA_W'(item_i.value) ^ SIGN_FLIP;
  assign short_now  = fill_q < eff_k_i;

  ksel_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_K)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    root_q      <= root_d;
    left_q      <= left_d;
    pos_q       <= pos_d;
    last_q      <= last_d;
    out_kth_q   <= out_kth_d;
    out_short_q <= out_short_d;
  end

  // Sequencer: next state, memory accesses, result beat
  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    left_d      = left_q;
    pos_d       = pos_q;
    fill_d      = fill_q;
    last_d      = last_q;
    out_kth_d   = out_kth_q;
    out_short_d = out_short_q;
    out_valid_d = out_valid_q && !result_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = pos_q;
    mem_wdata   = val_q;
    mem_raddr   = parent;
    item_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          val_d  = in_val;
          last_d = item_i.last;
          if (short_now) begin
            // Insert at the end of the heap
            pos_d  = AW'(fill_q);
            fill_d = fill_q + KW'(1);
            if (fill_q == '0) begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              mem_wdata = in_val;
              state_d   = ST_FIN;
            end else begin
              state_d = ST_UP_RD;
            end
          end else if (fill_q != '0 && in_val < root_q) begin
            // Replace the root, then sift down
            pos_d   = '0;
            state_d = ST_DN_RDL;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      ST_UP_RD: begin
        mem_raddr = parent;
        state_d   = ST_UP_CMP;
      end

      ST_UP_CMP: begin
        // Parent data is back: move it down or settle the new value
        mem_we = 1'b1;
        if (mem_rdata < val_q) begin
          mem_wdata = mem_rdata;
          pos_d     = parent;
          state_d   = (parent == '0) ? ST_PUT : ST_UP_RD;
        end else begin
          mem_wdata = val_q;
          state_d   = ST_FIN;
        end
      end

      ST_DN_RDL: begin
        mem_raddr = AW'(left_c);
        state_d   = (left_c < fill_c) ? ST_DN_RDR : ST_PUT;
      end

      ST_DN_RDR: begin
        left_d    = mem_rdata;
        mem_raddr = AW'(right_c);
        state_d   = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        // Pick the largest of hole value, left and right child
        mem_we = 1'b1;
        if (have_right && mem_rdata > left_q && mem_rdata > val_q) begin
          mem_wdata = mem_rdata;
          pos_d     = AW'(right_c);
          state_d   = ST_DN_RDL;
        end else if (left_q > val_q) begin
          mem_wdata = left_q;
          pos_d     = AW'(left_c);
          state_d   = ST_DN_RDL;
        end else begin
          mem_wdata = val_q;
          state_d   = ST_FIN;
        end
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_wdata = val_q;
        state_d   = ST_FIN;
      end

      ST_FIN: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if (!(out_valid_q && !result_o.ready)) begin
          out_valid_d = 1'b1;
          out_short_d = short_now;
          out_kth_d   = short_now ? '0 : (root_q ^ SIGN_FLIP);
          fill_d      = '0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Shadow copy of the root entry
  always_comb begin
    root_d = root_q;
    if (mem_we && mem_waddr == '0) begin
      root_d = mem_wdata;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kth_smallest = out_kth_q;
  assign result_o.short_set    = out_short_q;

endmodule

// ===== src/kth_smallest_heap_select.sv =====
// K-th smallest select: APB register, k clamping and heap engine.
// Sequence: one RAM read port; a beat is accepted only in idle, and the next one waits until
// it is done. Inserts read and compare the parent per level climbed; root replaces read and
// compare both children per level descended; then write-back, finish. Unkept ones just finish.
// Latency: the result beat is valid the cycle after the finish step of a last beat; that step
// waits while the output register still holds an untaken beat.
// Reset: asynchronous active low; clears fill count and sequencer, k_count reads 1.
module kth_smallest_heap_select import ksel_pkg::*; #(
  parameter int unsigned MAX_K = MAX_K_DEF,
  localparam int unsigned KW   = $clog2(MAX_K + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  ksel_item_if.sink           item_i,
  ksel_result_if.source       result_o
);

  logic [KCNT_W-1:0] k_q;
  logic [31:0]       k_ext;
  logic [31:0]       k_sat;
  logic [KW-1:0]     eff_k;

  // Configuration register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= KCNT_W'(1);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_K_COUNT) begin
      k_q <= pwdata[KCNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_K_COUNT) ? APB_DW'(k_q) : '0;

  // Effective k: zero acts as one, saturate at heap capacity
  assign k_ext = 32'(k_q);
  always_comb begin
    if (k_q == '0) begin
      k_sat = 32'd1;
    end else if (k_ext > 32'(MAX_K)) begin
      k_sat = 32'(MAX_K);
    end else begin
      k_sat = k_ext;
    end
  end
  assign eff_k = k_sat[KW-1:0];

  ksel_heap #(
    .MAX_K (MAX_K)
  ) u_heap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .eff_k_i  (eff_k),
    .item_i   (item_i),
    .result_o (result_o)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the k-th smallest heap select block.
module testbench;
  import ksel_pkg::*;

  localparam int unsigned HEAP_DEPTH    = MAX_K_DEF;
  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned SETTLE_CYCLES = 40;  // covers the slowest sift plus the output register
  localparam int unsigned DIR_N         = 25;

  typedef struct packed {
    logic signed [DATA_W-1:0] kth;
    logic                     short_set;
  } kth_beat_t;

  // One directed row: optional k write before the beat, then the beat itself.
  // A pinned row carries its expected result, read straight off the behavior.
  typedef struct packed {
    logic                     cfg_wr;
    logic [KCNT_W-1:0]        cfg_k;
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     pinned;
    logic signed [DATA_W-1:0] exp_kth;
    logic                     exp_short;
  } stim_row_t;

  localparam logic signed [DATA_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MOST_POS = 32'sh7fff_ffff;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ksel_item_if   item_bus ();
  ksel_result_if result_bus ();

  kth_smallest_heap_select uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // Heap model state, keys held sign-flipped so unsigned order is signed order
  logic [DATA_W-1:0] heap_keys [HEAP_DEPTH];
  int unsigned       heap_fill;
  logic [KCNT_W-1:0] k_shadow;

  kth_beat_t   pending_kth [$];
  int unsigned error_count;
  int unsigned burst_left;

  stim_row_t directed_rows [DIR_N] = '{
    // k = 1 after reset: both extremes come straight back
    '{1'b0, 7'd0,   MOST_NEG, 1'b1, 1'b1, MOST_NEG, 1'b0},
    '{1'b0, 7'd0,   MOST_POS, 1'b1, 1'b1, MOST_POS, 1'b0},
    // k = 0 behaves as 1: the minimum
    '{1'b1, 7'd0,   32'sd5,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   -32'sd3,  1'b1, 1'b1, -32'sd3,  1'b0},
    // k = 3 with a duplicate and a later larger value
    '{1'b1, 7'd3,   32'sd10,  1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   -32'sd20, 1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd30,  1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd30,  1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd40,  1'b1, 1'b0, 32'sd0,   1'b0},
    // short set at k = 3
    '{1'b0, 7'd0,   32'sd7,   1'b1, 1'b1, 32'sd0,   1'b1},
    // k above the heap size saturates; one beat is short
    '{1'b1, 7'd127, 32'sd1,   1'b1, 1'b1, 32'sd0,   1'b1},
    // k raised inside a set
    '{1'b1, 7'd2,   32'sd9,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd8,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b1, 7'd4,   32'sd7,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd6,   1'b1, 1'b0, 32'sd0,   1'b0},
    // k lowered inside a set: sift-down runs over all held entries
    '{1'b0, 7'd0,   32'sd1,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd2,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd3,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b1, 7'd2,   32'sd0,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   32'sd5,   1'b1, 1'b0, 32'sd0,   1'b0},
    // k raised past the fill inside a set: short at the last beat
    '{1'b1, 7'd1,   32'sd4,   1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b1, 7'd3,   32'sd5,   1'b1, 1'b1, 32'sd0,   1'b1},
    // k = 64 short set
    '{1'b1, 7'd64,  MOST_NEG, 1'b1, 1'b1, 32'sd0,   1'b1},
    // root replaced by the most negative value
    '{1'b1, 7'd1,   MOST_POS, 1'b0, 1'b0, 32'sd0,   1'b0},
    '{1'b0, 7'd0,   MOST_NEG, 1'b1, 1'b1, MOST_NEG, 1'b0}
  };

  function automatic int unsigned effective_k();
    int unsigned kv;
    kv = 32'(k_shadow);
    if (kv == 0) return 1;
    if (kv > HEAP_DEPTH) return HEAP_DEPTH;
    return kv;
  endfunction

  // Heap update for one accepted beat; a last beat yields the root
  function automatic void heap_take(input logic signed [DATA_W-1:0] v, input logic l,
                                    output logic emits, output kth_beat_t beat);
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] tmp;
    int unsigned       keff;
    int unsigned       pos;
    int unsigned       par;
    int unsigned       lt;
    int unsigned       rt;
    int unsigned       big;
    key   = v ^ SIGN_FLIP;
    keff  = effective_k();
    emits = 1'b0;
    beat  = '0;
    if (heap_fill < keff) begin
      // insert at the end, sift up
      pos = heap_fill;
      heap_keys[pos] = key;
      while (pos != 0) begin
        par = (pos - 1) / 2;
        if (heap_keys[par] < heap_keys[pos]) begin
          tmp = heap_keys[par];
          heap_keys[par] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = par;
        end else begin
          break;
        end
      end
      heap_fill++;
    end else if (heap_fill != 0 && key < heap_keys[0]) begin
      // replace the root, sift down over every held entry
      heap_keys[0] = key;
      pos = 0;
      forever begin
        lt  = 2 * pos + 1;
        rt  = lt + 1;
        big = pos;
        if (lt >= heap_fill) break;
        if (heap_keys[lt] > heap_keys[big]) big = lt;
        if (rt < heap_fill && heap_keys[rt] > heap_keys[big]) big = rt;
        if (big == pos) break;
        tmp = heap_keys[big];
        heap_keys[big] = heap_keys[pos];
        heap_keys[pos] = tmp;
        pos = big;
      end
    end
    if (l) begin
      emits = 1'b1;
      if (heap_fill < keff) begin
        beat.short_set = 1'b1;
      end else begin
        beat.kth = heap_keys[0] ^ SIGN_FLIP;
      end
      heap_fill = 0;
    end
  endfunction

  // Offer one beat in bursts with random gaps; predict once it is taken
  task automatic send_value(input logic signed [DATA_W-1:0] v, input logic l,
                            input logic pinned, input kth_beat_t pinned_beat);
    logic      emits;
    kth_beat_t beat;
    if (burst_left == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    item_bus.valid <= 1'b1;
    item_bus.value <= v;
    item_bus.last  <= l;
    do @(posedge clk_i); while (!item_bus.ready);
    burst_left--;
    heap_take(v, l, emits, beat);
    if (emits) pending_kth.push_back(pinned ? pinned_beat : beat);
  endtask

  // Drain every pending result, then let any silent sift finish
  task automatic wait_idle();
    item_bus.valid <= 1'b0;
    while (pending_kth.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_k(input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_K_COUNT;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    k_shadow = data[KCNT_W-1:0];
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      4, 5:    return $signed($urandom_range(0, 31)) - 32'sd16;
      6: begin
        case ($urandom_range(0, 3))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KCNT_W-1:0] pick_k();
    case ($urandom_range(0, 9))
      6:       return KCNT_W'(HEAP_DEPTH);
      7:       return '0;
      8:       return KCNT_W'($urandom_range(HEAP_DEPTH + 1, 127));
      9:       return KCNT_W'($urandom_range(9, HEAP_DEPTH - 1));
      default: return KCNT_W'($urandom_range(1, 8));
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result side: stall pattern of its own, check each taken beat
  initial begin
    int unsigned hold;
    logic        level;
    kth_beat_t   want;
    hold = 0;
    level = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_bus.valid && result_bus.ready) begin
        if (pending_kth.size() == 0) begin
          $error("unexpected result beat: kth_smallest %0d short_set %0b",
                 result_bus.kth_smallest, result_bus.short_set);
          error_count++;
        end else begin
          want = pending_kth.pop_front();
          if (result_bus.kth_smallest !== want.kth) begin
            $error("kth_smallest: expected %0d, got %0d", want.kth, result_bus.kth_smallest);
            error_count++;
          end
          if (result_bus.short_set !== want.short_set) begin
            $error("short_set: expected %0b, got %0b", want.short_set, result_bus.short_set);
            error_count++;
          end
        end
      end
      if (hold == 0) begin
        level = ($urandom_range(0, 2) != 0);
        hold  = level ? $urandom_range(1, 30) : $urandom_range(1, 15);
      end
      hold--;
      result_bus.ready <= level;
    end
  end

  // Stimulus
  initial begin
    int unsigned random_items;
    int unsigned keff;
    int unsigned set_len;
    int unsigned twist_at;
    logic [KCNT_W-1:0] k_pick;
    error_count  = 0;
    heap_fill    = 0;
    k_shadow     = 7'd1;
    burst_left   = 0;
    random_items = 0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    item_bus.valid <= 1'b0;
    item_bus.value <= '0;
    item_bus.last  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg_wr) begin
        wait_idle();
        write_k({25'd0, directed_rows[i].cfg_k});
      end
      send_value(directed_rows[i].value, directed_rows[i].last, directed_rows[i].pinned,
                 '{kth: directed_rows[i].exp_kth, short_set: directed_rows[i].exp_short});
    end

    // random phases: one k setting per phase, several sets under it, now and then changed mid-set
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      k_pick = pick_k();
      write_k({($urandom_range(0, 3) == 0) ? 25'($urandom) : 25'd0, k_pick});
      repeat ($urandom_range(2, 6)) begin
        keff = effective_k();
        if (keff > 1 && $urandom_range(0, 5) == 0)
          set_len = $urandom_range(1, keff - 1);
        else
          set_len = keff + $urandom_range(0, (keff < 8) ? 24 : 16);
        // now and then, k changes in the middle of a set
        twist_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, set_len - 1) : set_len;
        for (int unsigned j = 0; j < set_len; j++) begin
          if (j == twist_at) begin
            wait_idle();
            write_k({25'd0, pick_k()});
          end
          send_value(pick_value(), j == set_len - 1, 1'b0, '0);
          random_items++;
        end
      end
    end

    item_bus.valid <= 1'b0;
    while (pending_kth.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== kth_smallest_heap_select.f =====
src/ksel_pkg.sv
src/ksel_if.sv
src/ksel_ram.sv
src/ksel_heap.sv
src/kth_smallest_heap_select.sv
test/testbench.sv
